@@ design/jbt_pkg.sv @@
// shared types, token kinds and keyword tables for the json byte tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package jbt_pkg;

    // depth of the queue between front and back
    localparam int JBT_QUEUE_DEPTH = 4;

    // token kind codes
    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_LBRACK = 4'd2;
    localparam logic [3:0] KIND_RBRACK = 4'd3;
    localparam logic [3:0] KIND_COLON  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_TRUE   = 4'd8;
    localparam logic [3:0] KIND_END    = 4'd11;

    // keyword ids
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // lexer mode
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_STR    = 4'd1,
        MODE_INT    = 4'd2,
        MODE_FRAC   = 4'd3,
        MODE_EXP    = 4'd4,
        MODE_EXPDIG = 4'd5,
        MODE_KW     = 4'd6,
        MODE_DONE   = 4'd7
    } mode_t;

    // one result item
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data_byte;
        logic       has_data;
        logic       token_done;
        logic       bad_input;
        logic       last;
    } result_t;

    // all results caused by one input item (one or two)
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } rec_t;

    function automatic result_t mk_res(input logic [3:0] kind, input logic [7:0] data,
                                       input logic has, input logic done, input logic bad);
        result_t r;
        r.kind       = kind;
        r.data_byte  = data;
        r.has_data   = has;
        r.token_done = done;
        r.bad_input  = bad;
        r.last       = 1'b0;
        return r;
    endfunction

    // keyword length in bytes
    function automatic logic [2:0] kw_len(input logic [1:0] id);
        logic [2:0] len;
        case (id)
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            KW_NULL:  len = 3'd4;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    // keyword byte at a position
    function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
        logic [39:0] text;
        logic [7:0]  ch;
        case (id)
            KW_TRUE:  text = {"true", 8'h00};
            KW_FALSE: text = "false";
            KW_NULL:  text = {"null", 8'h00};
            default:  text = 40'h0;
        endcase
        case (pos)
            3'd0:    ch = text[39:32];
            3'd1:    ch = text[31:24];
            3'd2:    ch = text[23:16];
            3'd3:    ch = text[15:8];
            3'd4:    ch = text[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

endpackage

`default_nettype wire

@@ design/jbt_front.sv @@
// front of the tokenizer: accepts bytes, tracks the lexer mode, builds result records
// depends on jbt_pkg
`default_nettype none

module jbt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [7:0]    in_byte,
    input  wire logic          is_end,
    input  wire logic          q_full,
    output logic               q_wr,
    output jbt_pkg::rec_t      q_rec
);
    import jbt_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [1:0] kw_id_reg, kw_id_next;
    logic [2:0] kw_pos_reg, kw_pos_next;

    logic accept;
    assign accept = push && !q_full;

    // classification of a byte seen between tokens
    logic       idle_emit;
    result_t    idle_res;
    mode_t      idle_mode;
    logic [1:0] idle_kw_id;
    logic       idle_kw_start;

    always_comb
    begin
        idle_emit     = 1'b1;
        idle_res      = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
        idle_mode     = MODE_IDLE;
        idle_kw_id    = KW_TRUE;
        idle_kw_start = 1'b0;
        case (in_byte)
            "{": idle_res = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b1, 1'b0);
            "}": idle_res = mk_res(KIND_RBRACE, 8'h00, 1'b0, 1'b1, 1'b0);
            "[": idle_res = mk_res(KIND_LBRACK, 8'h00, 1'b0, 1'b1, 1'b0);
            "]": idle_res = mk_res(KIND_RBRACK, 8'h00, 1'b0, 1'b1, 1'b0);
            ":": idle_res = mk_res(KIND_COLON, 8'h00, 1'b0, 1'b1, 1'b0);
            ",": idle_res = mk_res(KIND_COMMA, 8'h00, 1'b0, 1'b1, 1'b0);
            "\"":
            begin
                idle_emit = 1'b0;
                idle_mode = MODE_STR;
            end
            "t", "f", "n":
            begin
                idle_emit     = 1'b0;
                idle_mode     = MODE_KW;
                idle_kw_start = 1'b1;
                idle_kw_id    = (in_byte == "t") ? KW_TRUE :
                                (in_byte == "f") ? KW_FALSE : KW_NULL;
            end
            " ", 8'd9, 8'd10, 8'd11, 8'd12, 8'd13:
            begin
                idle_emit = 1'b0;
            end
            default:
            begin
                if (in_byte == "-" || is_digit(in_byte))
                begin
                    idle_res  = mk_res(KIND_NUMBER, in_byte, 1'b1, 1'b0, 1'b0);
                    idle_mode = MODE_INT;
                end
                else
                begin
                    idle_mode = MODE_DONE;
                end
            end
        endcase
    end

    // number continuation and keyword match
    logic       num_take;
    mode_t      num_mode;
    logic       kw_match;
    logic       kw_complete;
    logic [3:0] kw_pos_inc;

    always_comb
    begin
        num_take = 1'b0;
        num_mode = MODE_IDLE;
        case (mode_reg)
            MODE_INT:
            begin
                if (is_digit(in_byte))
                begin
                    num_take = 1'b1;
                    num_mode = MODE_INT;
                end
                else if (in_byte == ".")
                begin
                    num_take = 1'b1;
                    num_mode = MODE_FRAC;
                end
                else if (in_byte == "e" || in_byte == "E")
                begin
                    num_take = 1'b1;
                    num_mode = MODE_EXP;
                end
            end
            MODE_FRAC:
            begin
                if (is_digit(in_byte))
                begin
                    num_take = 1'b1;
                    num_mode = MODE_FRAC;
                end
                else if (in_byte == "e" || in_byte == "E")
                begin
                    num_take = 1'b1;
                    num_mode = MODE_EXP;
                end
            end
            MODE_EXP:
            begin
                if (is_digit(in_byte) || in_byte == "+" || in_byte == "-")
                begin
                    num_take = 1'b1;
                    num_mode = MODE_EXPDIG;
                end
            end
            default:
            begin
                if (is_digit(in_byte))
                begin
                    num_take = 1'b1;
                    num_mode = MODE_EXPDIG;
                end
            end
        endcase

        kw_pos_inc  = {1'b0, kw_pos_reg} + 4'd1;
        kw_match    = (kw_id_reg != 2'd3) && (kw_pos_reg < kw_len(kw_id_reg))
                      && (in_byte == kw_char(kw_id_reg, kw_pos_reg));
        kw_complete = (kw_pos_inc == {1'b0, kw_len(kw_id_reg)});
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        kw_id_next  = kw_id_reg;
        kw_pos_next = kw_pos_reg;
        if (accept)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (is_end)
                        mode_next = MODE_DONE;
                    else
                    begin
                        mode_next = idle_mode;
                        if (idle_kw_start)
                        begin
                            kw_id_next  = idle_kw_id;
                            kw_pos_next = 3'd1;
                        end
                    end
                end
                MODE_STR:
                begin
                    if (is_end)
                        mode_next = MODE_DONE;
                    else if (in_byte == "\"")
                        mode_next = MODE_IDLE;
                end
                MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPDIG:
                begin
                    if (is_end)
                        mode_next = MODE_DONE;
                    else if (num_take)
                        mode_next = num_mode;
                    else
                    begin
                        mode_next = idle_mode;
                        if (idle_kw_start)
                        begin
                            kw_id_next  = idle_kw_id;
                            kw_pos_next = 3'd1;
                        end
                    end
                end
                MODE_KW:
                begin
                    if (is_end || !kw_match)
                        mode_next = MODE_DONE;
                    else if (kw_complete)
                    begin
                        mode_next   = MODE_IDLE;
                        kw_pos_next = 3'd0;
                    end
                    else
                        kw_pos_next = kw_pos_inc[2:0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // result records
    logic [1:0] n_res;
    result_t    r0, r1;

    always_comb
    begin
        n_res = 2'd0;
        r0    = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, 1'b0);
        r1    = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, 1'b0);
        case (mode_reg)
            MODE_IDLE:
            begin
                if (is_end)
                    n_res = 2'd1;
                else
                begin
                    n_res = {1'b0, idle_emit};
                    r0    = idle_res;
                end
            end
            MODE_STR:
            begin
                n_res = is_end ? 2'd2 : 2'd1;
                if (is_end || in_byte == "\"")
                    r0 = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                else
                    r0 = mk_res(KIND_STRING, in_byte, 1'b1, 1'b0, 1'b0);
            end
            MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPDIG:
            begin
                if (is_end)
                begin
                    n_res = 2'd2;
                    r0    = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                else if (num_take)
                begin
                    n_res = 2'd1;
                    r0    = mk_res(KIND_NUMBER, in_byte, 1'b1, 1'b0, 1'b0);
                end
                else
                begin
                    n_res = idle_emit ? 2'd2 : 2'd1;
                    r0    = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0);
                    r1    = idle_res;
                end
            end
            MODE_KW:
            begin
                if (is_end || !kw_match)
                begin
                    n_res = 2'd1;
                    r0    = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
                end
                else if (kw_complete)
                begin
                    n_res = 2'd1;
                    r0    = mk_res(KIND_TRUE + {2'b00, kw_id_reg}, 8'h00, 1'b0, 1'b1, 1'b0);
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    assign q_wr      = accept && (n_res != 2'd0);
    assign q_rec.two = (n_res == 2'd2);
    assign q_rec.r0  = r0;
    assign q_rec.r1  = r1;

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            kw_id_reg  <= KW_TRUE;
            kw_pos_reg <= 3'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            kw_id_reg  <= kw_id_next;
            kw_pos_reg <= kw_pos_next;
        end
    end

    // once finished, nothing more is written
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DONE) |-> !q_wr)
        else $error("record written after end of stream");

    // finished mode is never left
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DONE) |=> (mode_reg == MODE_DONE))
        else $error("left finished mode without reset");

    // an accepted end item always finishes the stream unless already finished
    a_end_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (mode_reg == MODE_DONE))
        else $error("end item did not finish the stream");

endmodule

`default_nettype wire

@@ design/jbt_queue.sv @@
// short queue of result records between front and back
// depends on jbt_pkg
`default_nettype none

module jbt_queue #(
    parameter int DEPTH = jbt_pkg::JBT_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire jbt_pkg::rec_t wr_rec,
    input  wire logic          rd_en,
    output jbt_pkg::rec_t      rd_rec,
    output logic               full,
    output logic               empty
);
    import jbt_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_wr, do_rd;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_rec = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    // the front never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("write into full queue");

    // count tracks transfers in and out
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!do_wr && !do_rd) |=> $stable(count_reg))
        else $error("queue count moved without a transfer");

    // a record with two results has its last mark on the second only
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rd_rec.two) |-> (rd_rec.r1.last && !rd_rec.r0.last))
        else $error("two-result record with bad last marks");

endmodule

`default_nettype wire

@@ design/jbt_back.sv @@
// back of the tokenizer: unpacks queued records into single results for the output
// depends on jbt_pkg
`default_nettype none

module jbt_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jbt_pkg::rec_t q_rec,
    input  wire logic          q_empty,
    output logic               q_rd,
    input  wire logic          pop,
    output logic               empty,
    output jbt_pkg::result_t   res
);
    import jbt_pkg::*;

    logic rec_valid_reg, rec_valid_next;
    rec_t rec_reg;
    logic idx_reg, idx_next;

    logic at_last, out_xfer;

    assign empty    = !rec_valid_reg;
    assign out_xfer = pop && rec_valid_reg;
    assign at_last  = !rec_reg.two || idx_reg;
    assign q_rd     = !q_empty && (!rec_valid_reg || (out_xfer && at_last));
    assign res      = idx_reg ? rec_reg.r1 : rec_reg.r0;

    // output record control
    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        idx_next       = idx_reg;
        if (q_rd)
        begin
            rec_valid_next = 1'b1;
            idx_next       = 1'b0;
        end
        else if (out_xfer)
        begin
            if (at_last)
                rec_valid_next = 1'b0;
            else
                idx_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (q_rd)
            rec_reg <= q_rec;
    end

    // the shown result is a defined token kind
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg |-> (res.kind <= KIND_END))
        else $error("result with undefined kind");

    // second result only shown for two-result records
    a_idx_two: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && idx_reg) |-> rec_reg.two)
        else $error("second result of a one-result record");

    // a held result does not change while waiting
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && !pop) |=> (rec_valid_reg && $stable(res)))
        else $error("waiting result changed");

endmodule

`default_nettype wire

@@ design/json_byte_tokenizer_top.sv @@
// json byte tokenizer: one byte or end item in, token results out, queue style on both sides
// an accepted item's record is written into the queue storage, then loaded into the back's
// record register, which drives the result ports; results leave from there when the path is clear
// throughput: one item per cycle unless full; an item's two results leave one after the other
// the front-to-back record queue decouples the lexer from output stalls
// reset: asynchronous, active low; the lexer returns to idle and all queues empty
// depends on jbt_pkg, jbt_front, jbt_queue, jbt_back
`default_nettype none

module json_byte_tokenizer_top #(
    parameter int QUEUE_DEPTH = jbt_pkg::JBT_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [3:0]      kind,
    output logic [7:0]      data_byte,
    output logic            has_data,
    output logic            token_done,
    output logic            bad_input,
    output logic            last
);
    import jbt_pkg::*;

    logic    q_wr, q_rd, q_full, q_empty;
    rec_t    wr_rec, rd_rec;
    result_t res;

    assign full = q_full;

    // lexer front
    jbt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_byte (in_byte),
        .is_end  (is_end),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_rec   (wr_rec)
    );

    // record queue
    jbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_rec (wr_rec),
        .rd_en  (q_rd),
        .rd_rec (rd_rec),
        .full   (q_full),
        .empty  (q_empty)
    );

    // result back
    jbt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rec   (rd_rec),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign kind       = res.kind;
    assign data_byte  = res.data_byte;
    assign has_data   = res.has_data;
    assign token_done = res.token_done;
    assign bad_input  = res.bad_input;
    assign last       = res.last;

endmodule

`default_nettype wire
